[rtl/core/teaching_cpu_instruction_executor_macros.svh]
// ----------------------------------------------------------------------------
// Instruction executor assertion macros
// Clocked, reset-qualified concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef TEACHING_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH
`define TEACHING_CPU_INSTRUCTION_EXECUTOR_MACROS_SVH

// property checked at every rising edge outside reset
`define TCIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never hold
`define TCIE_ASSERT_NEVER(lbl, cond, msg) \
  `TCIE_ASSERT(lbl, !(cond), msg)

`endif

[rtl/core/tcie_pkg.sv]
// ----------------------------------------------------------------------------
// Instruction executor package
// Shared constants, opcodes and decoded-instruction types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcie_pkg;

  localparam int RegCountDef  = 32;
  localparam int DataWordsDef = 4096;
  localparam int QueueDepth   = 4;
  localparam int InstrBytes   = 4;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDL  = 5'd1,
    OP_SUB   = 5'd2,
    OP_SUBL  = 5'd3,
    OP_MUL   = 5'd4,
    OP_AND   = 5'd5,
    OP_OR    = 5'd6,
    OP_EXOR  = 5'd7,
    OP_MOVC  = 5'd8,
    OP_LOAD  = 5'd9,
    OP_LDR   = 5'd10,
    OP_STORE = 5'd11,
    OP_STR   = 5'd12,
    OP_BZ    = 5'd13,
    OP_BNZ   = 5'd14,
    OP_JUMP  = 5'd15,
    OP_HALT  = 5'd16
  } op_e;

  typedef struct packed {
    logic wr;
    logic setz;
    logic ld;
    logic st;
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [4:0]  op;
    logic [15:0] pc;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [4:0]  rs3;
    logic [15:0] imm;
  } dec_t;

  typedef struct packed {
    logic clr_busy;
    logic halted;
  } bk_stat_t;

endpackage

`default_nettype wire

[rtl/core/tcie_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcie_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcie_front.sv]
// ----------------------------------------------------------------------------
// Instruction executor front end
// Accepts input beats, classifies the opcode and registers the decoded item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcie_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [63:0]   s_axis_tdata_i,
  output tcie_pkg::dec_t     dec_o,
  output logic               push_o,
  input  wire logic          q_ready_i
);
  import tcie_pkg::*;

  logic f_v_q;
  dec_t f_d_q, f_d_d;

  always_comb begin
    f_d_d     = '0;
    f_d_d.op  = s_axis_tdata_i[4:0];
    f_d_d.pc  = s_axis_tdata_i[20:5];
    f_d_d.rd  = s_axis_tdata_i[25:21];
    f_d_d.rs1 = s_axis_tdata_i[30:26];
    f_d_d.rs2 = s_axis_tdata_i[35:31];
    f_d_d.rs3 = s_axis_tdata_i[40:36];
    f_d_d.imm = s_axis_tdata_i[56:41];
    case (s_axis_tdata_i[4:0])
      OP_ADD, OP_ADDL, OP_SUB, OP_SUBL, OP_MUL: begin
        f_d_d.cls.wr   = 1'b1;
        f_d_d.cls.setz = 1'b1;
      end
      OP_AND, OP_OR, OP_EXOR, OP_MOVC: begin
        f_d_d.cls.wr = 1'b1;
      end
      OP_LOAD, OP_LDR: begin
        f_d_d.cls.wr = 1'b1;
        f_d_d.cls.ld = 1'b1;
      end
      OP_STORE, OP_STR: begin
        f_d_d.cls.st = 1'b1;
      end
      default: begin
        f_d_d.cls = '0;
      end
    endcase
  end

  assign push_o          = f_v_q && q_ready_i;
  assign s_axis_tready_o = !f_v_q || q_ready_i;
  assign dec_o           = f_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      f_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      f_d_q <= f_d_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcie_fifo.sv]
// ----------------------------------------------------------------------------
// Instruction queue
// Small flop FIFO between front end and execute back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcie_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      head_o,
  output logic                  valid_o
);

  localparam int AW = $clog2(Depth);

  logic [Width-1:0] ent_q [Depth];
  logic [AW:0]      wp_q, rp_q;

  assign valid_o = wp_q != rp_q;
  assign ready_o = (wp_q - rp_q) != (AW+1)'(Depth);
  assign head_o  = ent_q[rp_q[AW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q[AW-1:0]] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcie_back.sv]
// ----------------------------------------------------------------------------
// Instruction executor back end
// Register read, execute/memory, writeback and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcie_back #(
  parameter int RegCount  = tcie_pkg::RegCountDef,
  parameter int DataWords = tcie_pkg::DataWordsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  tcie_pkg::dec_t      head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  wire logic           m_axis_tready_i,
  output logic [63:0]         m_axis_tdata_o,
  output tcie_pkg::bk_stat_t  stat_o
);
  import tcie_pkg::*;

  localparam int RIW = $clog2(RegCount);
  localparam int DAW = $clog2(DataWords);

  logic           adv, clr_busy;
  logic [DAW:0]   clr_cnt_q;
  logic [4:0]     hsel [3];
  logic [4:0]     ssel [3];
  logic [31:0]    rf_rd [3];
  logic [RegCount-1:0] rf_vld_q;
  logic           rf_we;

  logic           s2_v_q;
  dec_t           s2_d_q;
  logic [2:0]     s2_inr_q, s2_rv_q, s2_bv_q;
  logic [31:0]    s2_bval_q [3];
  logic [31:0]    opv [3];

  logic           zf_q, hlt_q, zf_d, hlt_d;
  logic [31:0]    imm32, prod, val, maddr;
  logic [15:0]    nxt;
  logic           redir, wr, wr_eff, mw, ld;

  logic           s3_v_q, s3_wr_q, s3_ld_q, s3_redir_q, s3_mw_q, s3_zf_q, s3_hlt_q;
  logic [4:0]     s3_rd_q;
  logic [31:0]    s3_val_q, s3_wval, dram_rd;
  logic [15:0]    s3_nxt_q;

  logic           ov_q;
  logic [63:0]    od_q;

  assign adv      = !ov_q || m_axis_tready_i;
  assign clr_busy = clr_cnt_q != (DAW+1)'(DataWords);
  assign pop_o    = head_valid_i && adv && !clr_busy;
  assign stat_o   = '{clr_busy: clr_busy, halted: hlt_q};

  assign hsel[0] = head_i.rs1;
  assign hsel[1] = head_i.rs2;
  assign hsel[2] = head_i.rs3;
  assign ssel[0] = s2_d_q.rs1;
  assign ssel[1] = s2_d_q.rs2;
  assign ssel[2] = s2_d_q.rs3;

  assign rf_we   = adv && s3_v_q && s3_wr_q;
  assign s3_wval = s3_ld_q ? dram_rd : s3_val_q;

  for (genvar k = 0; k < 3; k++) begin : g_rf
    tcie_ram #(.Width(32), .Depth(RegCount)) u_rf (
      .clk_i  (clk_i),
      .we_i   (rf_we),
      .waddr_i(s3_rd_q[RIW-1:0]),
      .wdata_i(s3_wval),
      .re_i   (pop_o),
      .raddr_i(hsel[k][RIW-1:0]),
      .rdata_o(rf_rd[k])
    );

    always_comb begin
      if (!s2_inr_q[k]) begin
        opv[k] = '0;
      end else if (s3_v_q && s3_wr_q && s3_rd_q == ssel[k]) begin
        opv[k] = s3_wval;
      end else if (s2_bv_q[k]) begin
        opv[k] = s2_bval_q[k];
      end else if (s2_rv_q[k]) begin
        opv[k] = rf_rd[k];
      end else begin
        opv[k] = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pop_o) begin
        s2_inr_q[k]  <= {1'b0, hsel[k]} < 6'(RegCount);
        s2_rv_q[k]   <= rf_vld_q[hsel[k][RIW-1:0]];
        s2_bv_q[k]   <= s3_v_q && s3_wr_q && s3_rd_q == hsel[k];
        s2_bval_q[k] <= s3_wval;
      end
    end
  end

  assign imm32 = {{16{s2_d_q.imm[15]}}, s2_d_q.imm};
  assign prod  = opv[0] * opv[1];

  always_comb begin
    val   = '0;
    maddr = '0;
    nxt   = s2_d_q.pc + 16'(InstrBytes);
    redir = 1'b0;
    wr    = s2_d_q.cls.wr;
    mw    = 1'b0;
    ld    = 1'b0;
    zf_d  = zf_q;
    hlt_d = hlt_q;
    if (s2_v_q && hlt_q) begin
      nxt = s2_d_q.pc;
      wr  = 1'b0;
    end else if (s2_v_q) begin
      case (s2_d_q.op)
        OP_ADD:   val = opv[0] + opv[1];
        OP_ADDL:  val = opv[0] + imm32;
        OP_SUB:   val = opv[0] - opv[1];
        OP_SUBL:  val = opv[0] - imm32;
        OP_MUL:   val = prod;
        OP_AND:   val = opv[0] & opv[1];
        OP_OR:    val = opv[0] | opv[1];
        OP_EXOR:  val = opv[0] ^ opv[1];
        OP_MOVC:  val = imm32;
        OP_LOAD: begin
          maddr = opv[0] + imm32;
          ld    = 1'b1;
        end
        OP_LDR: begin
          maddr = opv[0] + opv[1];
          ld    = 1'b1;
        end
        OP_STORE: begin
          maddr = opv[1] + imm32;
          mw    = 1'b1;
        end
        OP_STR: begin
          maddr = opv[1] + opv[2];
          mw    = 1'b1;
        end
        OP_BZ: begin
          if (zf_q) begin
            nxt   = s2_d_q.pc + s2_d_q.imm;
            redir = 1'b1;
            zf_d  = 1'b0;
          end
        end
        OP_BNZ: begin
          if (!zf_q) begin
            nxt   = s2_d_q.pc + s2_d_q.imm;
            redir = 1'b1;
          end
        end
        OP_JUMP: begin
          maddr = opv[0] + imm32;
          nxt   = maddr[15:0];
          redir = 1'b1;
        end
        OP_HALT: begin
          nxt   = s2_d_q.pc;
          hlt_d = 1'b1;
        end
        default: begin
          val = '0;
        end
      endcase
      if (s2_d_q.cls.setz) begin
        zf_d = val == '0;
      end
    end
  end

  assign wr_eff = s2_v_q && wr && ({1'b0, s2_d_q.rd} < 6'(RegCount));

  tcie_ram #(.Width(32), .Depth(DataWords)) u_dmem (
    .clk_i  (clk_i),
    .we_i   (clr_busy || (adv && mw)),
    .waddr_i(clr_busy ? clr_cnt_q[DAW-1:0] : maddr[DAW-1:0]),
    .wdata_i(clr_busy ? 32'd0 : opv[0]),
    .re_i   (adv && ld),
    .raddr_i(maddr[DAW-1:0]),
    .rdata_o(dram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      rf_vld_q  <= '0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      ov_q      <= 1'b0;
      zf_q      <= 1'b0;
      hlt_q     <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (rf_we) begin
        rf_vld_q[s3_rd_q[RIW-1:0]] <= 1'b1;
      end
      if (adv) begin
        s2_v_q <= pop_o;
        s3_v_q <= s2_v_q;
        ov_q   <= s3_v_q;
        zf_q   <= zf_d;
        hlt_q  <= hlt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_d_q <= head_i;
    end
    if (adv) begin
      s3_wr_q    <= wr_eff;
      s3_rd_q    <= wr_eff ? s2_d_q.rd : 5'd0;
      s3_val_q   <= val;
      s3_ld_q    <= ld;
      s3_nxt_q   <= nxt;
      s3_redir_q <= redir;
      s3_mw_q    <= mw;
      s3_zf_q    <= zf_d;
      s3_hlt_q   <= hlt_d;
      od_q       <= {6'd0, s3_hlt_q, s3_zf_q, s3_mw_q,
                     s3_wr_q ? s3_wval : 32'd0, s3_rd_q, s3_wr_q, s3_redir_q, s3_nxt_q};
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

endmodule

`default_nettype wire

[rtl/core/teaching_cpu_instruction_executor.sv]
// ----------------------------------------------------------------------------
// Teaching CPU instruction executor
// Executes one decoded instruction per input beat, in program order.
// ----------------------------------------------------------------------------
// Input beats carry one decoded instruction; each produces one output beat
// with the next PC, register/memory write indications and the flags.
// A beat passes the front register, queue, register read, execute/memory
// access and output register. Throughput is one instruction per cycle
// while the output is not stalled and the memory clear is done; the data
// memory has one write and one read port, the execute stage one multiplier,
// and results are forwarded so dependent instructions follow back to back.
// After reset the data memory is zeroed one word per cycle, all DATA_WORDS
// words in turn; beats are taken until the queue fills, execution starts
// once the pass is done. The register file reads as zero until written.
// A stalled output holds its beat and freezes the back end; the queue lets
// the front keep taking beats meanwhile. HALT freezes state until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "teaching_cpu_instruction_executor_macros.svh"

module teaching_cpu_instruction_executor #(
  parameter int REG_COUNT  = tcie_pkg::RegCountDef,
  parameter int DATA_WORDS = tcie_pkg::DataWordsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // opcode, instr_addr, dest_sel, src_a_sel, src_b_sel, src_c_sel, literal
  input  wire logic [63:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // next_pc, redirect, reg_write, written_reg, written_value, mem_write,
  // zero_now, halted_now
  output logic [63:0]      m_axis_tdata_o
);
  import tcie_pkg::*;

  dec_t     f_dec, q_head;
  logic     push, q_ready, pop, q_valid;
  bk_stat_t stat;

  tcie_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .dec_o          (f_dec),
    .push_o         (push),
    .q_ready_i      (q_ready)
  );

  tcie_fifo #(.Width($bits(dec_t)), .Depth(QueueDepth)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(f_dec),
    .ready_o(q_ready),
    .pop_i  (pop),
    .head_o (q_head),
    .valid_o(q_valid)
  );

  tcie_back #(.RegCount(REG_COUNT), .DataWords(DATA_WORDS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .head_valid_i   (q_valid),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .stat_o         (stat)
  );

  `TCIE_ASSERT_NEVER(a_no_issue_clr, stat.clr_busy && pop, "issue during memory clear")
  `TCIE_ASSERT(a_halt_sticky, stat.halted |=> stat.halted, "halted flag dropped")
  `TCIE_ASSERT_NEVER(a_pop_empty, pop && !q_valid, "pop from empty queue")

endmodule

`default_nettype wire
